// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, constants and helpers shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH          = 256;
  localparam int PRIORITY_WIDTH = 16;
  localparam int PAYLOAD_WIDTH  = 16;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic                      op;
    logic [PRIORITY_WIDTH-1:0] priority_req;
    logic [PAYLOAD_WIDTH-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic [PRIORITY_WIDTH-1:0] out_priority;
    logic [PAYLOAD_WIDTH-1:0]  out_payload;
    logic [CNT_W-1:0]          occupancy;
  } out_item_t;

  typedef struct packed {
    logic [PRIORITY_WIDTH-1:0] pri;
    logic [PAYLOAD_WIDTH-1:0]  pay;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic capture;    // latch the accepted beat, start insert index at count
    logic rd_prev;    // read the slot below the insert index
    logic shift;      // move the read entry up one slot, step index down
    logic place;      // write the new entry at the insert index, emit result
    logic rd_head;    // read the front slot
    logic pop;        // drop the front entry, emit it
    logic rej_full;   // emit full status
    logic rej_empty;  // emit empty status
  } spq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic k_zero;
    logic greater;    // read entry priority above the new one
    logic out_free;
  } spq_stat_t;

  // circular slot at offset from head; sum stays below twice the depth
  function automatic idx_t slot_of(input idx_t head, input cnt_t offset);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(offset);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== hdl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Command sequencer: accepts one queue command at a time and steps the
// datapath through the insertion walk, the front read or a reject status.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  spq_pkg::spq_stat_t stat,
  output spq_pkg::spq_cmd_t  cmd
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_ENQ_PLACE,
    S_DEQ_RD,
    S_DEQ_POP,
    S_REJ_FULL,
    S_REJ_EMPTY
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == OP_ENQ) begin
            state_nxt = stat.full ? S_REJ_FULL : S_ENQ_RD;
          end else begin
            state_nxt = stat.empty ? S_REJ_EMPTY : S_DEQ_RD;
          end
        end
      end
      S_ENQ_RD: begin
        if (stat.k_zero) begin
          state_nxt = S_ENQ_PLACE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_ENQ_CMP;
        end
      end
      S_ENQ_CMP: begin
        if (stat.greater) begin
          cmd.shift = 1'b1;
          state_nxt = S_ENQ_RD;
        end else begin
          state_nxt = S_ENQ_PLACE;
        end
      end
      S_ENQ_PLACE: begin
        if (stat.out_free) begin
          cmd.place = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DEQ_RD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_DEQ_POP;
      end
      S_DEQ_POP: begin
        if (stat.out_free) begin
          cmd.pop   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REJ_FULL: begin
        if (stat.out_free) begin
          cmd.rej_full = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REJ_EMPTY: begin
        if (stat.out_free) begin
          cmd.rej_empty = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/spq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Entry store, head and count registers, insert index, compare and the
// result register.
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::in_item_t  in_data,
  input  spq_pkg::spq_cmd_t  cmd,
  output spq_pkg::spq_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  entry_t mem [DEPTH];

  idx_t   head_r, head_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   k_r, k_nxt;
  logic [PRIORITY_WIDTH-1:0] pri_r;
  logic [PAYLOAD_WIDTH-1:0]  pay_r;
  entry_t rd_data_r;

  logic   rd_en, wr_en;
  idx_t   rd_addr, wr_addr;
  entry_t wr_data;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      emit;

  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.k_zero   = (k_r == '0);
  assign stat.greater  = (rd_data_r.pri > pri_r);
  assign stat.out_free = !out_valid_r || out_ready;

  // store port control
  always_comb begin
    rd_en   = cmd.rd_prev | cmd.rd_head;
    rd_addr = cmd.rd_head ? head_r : slot_of(head_r, k_r - CNT_W'(1));
    wr_en   = cmd.shift | cmd.place;
    wr_addr = slot_of(head_r, k_r);
    wr_data = cmd.shift ? rd_data_r : entry_t'{pri: pri_r, pay: pay_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    if (cmd.capture) begin
      k_nxt = count_r;
    end
    if (cmd.shift) begin
      k_nxt = k_r - CNT_W'(1);
    end
    if (cmd.place) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
      head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + IDX_W'(1);
    end
  end

  // result beat
  always_comb begin
    emit         = cmd.place | cmd.pop | cmd.rej_full | cmd.rej_empty;
    out_data_nxt = out_data_r;
    if (emit) begin
      out_data_nxt.status       = ST_DONE;
      out_data_nxt.out_priority = '0;
      out_data_nxt.out_payload  = '0;
      out_data_nxt.occupancy    = count_nxt;
      if (cmd.rej_full) begin
        out_data_nxt.status = ST_FULL;
      end
      if (cmd.rej_empty) begin
        out_data_nxt.status = ST_EMPTY;
      end
      if (cmd.pop) begin
        out_data_nxt.out_priority = rd_data_r.pri;
        out_data_nxt.out_payload  = rd_data_r.pay;
      end
    end
    out_valid_nxt = emit | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
    if (cmd.capture) begin
      pri_r <= in_data.priority_req;
      pay_r <= in_data.payload;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// Bounded priority queue held in ascending priority order in a circular
// single-port-read store; smallest priority leaves first, ties in order.
// ----------------------------------------------------------------------------
//  channel  ports                          beat
//  in       in_valid in_ready in_data      op, priority_req, payload
//  out      out_valid out_ready out_data   status, out_priority,
//                                          out_payload, occupancy
//
//  one command at a time, one result beat per command
//  enqueue: the walk runs through the store read port, reading the slot
//  below the insert index and then comparing, moving each larger entry up
//  one slot, until the read entry is not larger or the front is reached
//  dequeue reads the front, then pops it; a stalled result holds the sequencer
//  synchronous active-low reset empties the queue, no store clearing
// ----------------------------------------------------------------------------
module sorted_priority_queue_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output spq_pkg::out_item_t out_data
);
  import spq_pkg::*;

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spq_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority queue. A directed run covers
// the empty and tie cases and the extreme keys; random phases of mixed
// commands follow, plus full fill-and-drain passes. Expected results come
// from a sorted shadow list and are checked beat by beat.
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam int TOTAL_CMDS  = 1950;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  sorted_priority_queue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_item_t  cmd_backlog[$];
  out_item_t pending_results[$];
  entry_t    sorted_entries[$];

  int   cmds_queued = 0;
  int   cmds_taken = 0;
  int   gen_count = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  logic calm = 1'b0;
  logic in_taken = 1'b0;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [PRIORITY_WIDTH-1:0] rand_pri(input int mode);
    logic [PRIORITY_WIDTH-1:0] base;
    base = PRIORITY_WIDTH'($urandom_range(0, 65535));
    case (mode)
      1: return PRIORITY_WIDTH'($urandom_range(0, 7));
      2: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return base;
        endcase
      end
      3: return {base[PRIORITY_WIDTH-1:5], 5'(cmds_queued % 7)};
      default: return base;
    endcase
  endfunction

  // sorted insert after equal keys, pop from the front
  function automatic out_item_t apply_command(input in_item_t cmd);
    out_item_t res;
    entry_t    ent;
    int        pos;
    res = '0;
    res.status = ST_DONE;
    if (cmd.op == OP_ENQ) begin
      if (sorted_entries.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].pri <= cmd.priority_req) begin
          pos++;
        end
        ent.pri = cmd.priority_req;
        ent.pay = cmd.payload;
        sorted_entries.insert(pos, ent);
      end
    end else begin
      if (sorted_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        ent = sorted_entries.pop_front();
        res.out_priority = ent.pri;
        res.out_payload  = ent.pay;
      end
    end
    res.occupancy = cnt_t'(sorted_entries.size());
    return res;
  endfunction

  task automatic push_cmd(input logic op, input logic [PRIORITY_WIDTH-1:0] pri,
                          input logic [PAYLOAD_WIDTH-1:0] pay);
    in_item_t cmd;
    cmd.op = op;
    cmd.priority_req = pri;
    cmd.payload = pay;
    cmd_backlog.push_back(cmd);
    cmds_queued++;
    if (op == OP_ENQ && gen_count < DEPTH) gen_count++;
    if (op == OP_DEQ && gen_count > 0) gen_count--;
  endtask

  task automatic wait_drained();
    while (cmds_taken < cmds_queued || pending_results.size() > 0) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // beat still on offer
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      in_data  <= cmd_backlog.pop_front();
      in_valid <= 1'b1;
      send_gap <= calm ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with its own long hold-off counter
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) recv_gap <= pick_gap();
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing expected: %h", out_data);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.status !== exp_res.status || out_data.out_priority !== exp_res.out_priority
            || out_data.out_payload !== exp_res.out_payload
            || out_data.occupancy !== exp_res.occupancy) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp st=%0d pri=%h pay=%h occ=%0d  got st=%0d pri=%h pay=%h occ=%0d",
                     exp_res.status, exp_res.out_priority, exp_res.out_payload,
                     exp_res.occupancy, out_data.status, out_data.out_priority,
                     out_data.out_payload, out_data.occupancy);
          end
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      pending_results.push_back(apply_command(in_data));
      cmds_taken++;
    end
    in_taken <= rst_n && in_valid && in_ready;
  end

  // watchdog on cycles with work outstanding and no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cmds_taken == cmds_queued && pending_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[sorted_priority_queue_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    int k;
    int enq_pct;
    int pri_mode;
    int phase;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty reject, extreme keys, ties in arrival order
    push_cmd(OP_DEQ, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_ENQ, 16'h0000, 16'h0000);
    push_cmd(OP_ENQ, 16'hFFFF, 16'hFFFF);
    push_cmd(OP_ENQ, 16'h8000, 16'h1234);
    push_cmd(OP_ENQ, 16'h8000, 16'h5678);
    push_cmd(OP_ENQ, 16'h0000, 16'hFFFF);
    push_cmd(OP_ENQ, 16'h7FFF, 16'hAAAA);
    push_cmd(OP_ENQ, 16'h0001, 16'h5555);
    for (k = 0; k < 7; k++) push_cmd(OP_DEQ, 16'h0000, 16'h0000);
    push_cmd(OP_DEQ, 16'h0000, 16'h0000);
    push_cmd(OP_ENQ, 16'hFFFF, 16'h0000);
    push_cmd(OP_ENQ, 16'hFFFF, 16'h0001);
    push_cmd(OP_DEQ, 16'h5A5A, 16'hA5A5);
    push_cmd(OP_DEQ, 16'h0000, 16'h0000);
    push_cmd(OP_DEQ, 16'h0000, 16'h0000);
    wait_drained();

    phase = 0;
    while (cmds_queued < TOTAL_CMDS) begin
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 2 || $urandom_range(0, 7) == 0) wait_drained();
      if (phase == 1 || $urandom_range(0, 9) == 0) hold_reqs++;
      pri_mode = $urandom_range(0, 3);
      if (phase == 0 || phase == 6) begin
        // fill to full, knock on the full queue, churn at the top, drain past empty
        while (gen_count < DEPTH) begin
          push_cmd(OP_ENQ, rand_pri(pri_mode), PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
        for (k = 0; k < 2; k++) begin
          push_cmd(OP_ENQ, rand_pri(pri_mode), PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
        for (k = 0; k < 10; k++) begin
          push_cmd(k[0] ? OP_ENQ : OP_DEQ, rand_pri(pri_mode),
                   PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
        while (gen_count > 0) begin
          push_cmd(OP_DEQ, rand_pri(0), PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
        for (k = 0; k < 2; k++) begin
          push_cmd(OP_DEQ, rand_pri(0), PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
      end else begin
        case ($urandom_range(0, 3))
          0: enq_pct = 30;
          1: enq_pct = 50;
          2: enq_pct = 70;
          default: enq_pct = 90;
        endcase
        n = $urandom_range(20, 80);
        for (k = 0; k < n; k++) begin
          push_cmd(($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ, rand_pri(pri_mode),
                   PAYLOAD_WIDTH'($urandom_range(0, 65535)));
        end
      end
      while (cmd_backlog.size() > 2) @(negedge clk);
      phase++;
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[sorted_priority_queue_top] OK");
    end else begin
      $display("[sorted_priority_queue_top] ERROR");
    end
    $finish;
  end

endmodule
